/* rtl/session_record_sort_search_table_core_macros.svh */
// Assertion macros used by the session table core.
`ifndef SESSION_RECORD_SORT_SEARCH_TABLE_CORE_MACROS_SVH
`define SESSION_RECORD_SORT_SEARCH_TABLE_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SRT_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SRT_ASSERT_NXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

/* rtl/srst_pkg.sv */
// Shared types and constants for the session record table.
package srst_pkg;
  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_FIND  = 3'd2;
  localparam logic [2:0] MODE_SORT  = 3'd3;
  localparam logic [2:0] MODE_STATS = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [1:0] KEY_ID     = 2'd0;
  localparam logic [1:0] KEY_ENERGY = 2'd1;
  localparam logic [1:0] KEY_COST   = 2'd2;
  localparam logic [1:0] KEY_TIME   = 2'd3;

  localparam logic [16:0] POWER_MAX  = 17'd100000;
  localparam logic [14:0] HOURS_MAX  = 15'd16800;
  localparam logic [13:0] TARIFF_MAX = 14'd10000;

  typedef struct packed {
    logic [7:0]  id;
    logic [16:0] power;
    logic [14:0] hours;
    logic [13:0] tariff;
    logic [30:0] energy;
    logic [44:0] cost;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_MUL1, S_ADD_MUL2, S_ADD_CMUL, S_ADD_WR,
    S_READ_WAIT, S_FIND_RD, S_FIND_CHK,
    S_SORT_RDI, S_SORT_WI, S_SORT_RDJ, S_SORT_CMP, S_SORT_PUT,
    S_DIV, S_OUT
  } state_t;

  // Key extraction; every key fits in 45 bits.
  function automatic logic [44:0] key_of(rec_t r, logic [1:0] k);
    logic [44:0] v;
    case (k)
      KEY_ID:     v = {37'd0, r.id};
      KEY_ENERGY: v = {14'd0, r.energy};
      KEY_COST:   v = r.cost;
      default:    v = {30'd0, r.hours};
    endcase
    return v;
  endfunction
endpackage

/* rtl/srst_div.sv */
// Restoring divider: one quotient bit per cycle.
module srst_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [51:0] quotient
);
  import srst_pkg::*;
  logic [51:0] q;
  logic [8:0]  rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [8:0]  trial;

  assign trial = {rem[7:0], q[51]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd51) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= 9'd0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        q   <= {q[50:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[50:0], 1'b0};
      end
    end
  end

  assign quotient = q;
endmodule

/* rtl/session_record_sort_search_table_core.sv */
// Top level of the charging-session record table.
// One item at a time. Add multiplies and writes the new record, read-at reads
// one stored record, stats runs a bit-serial divide for the average, find scans
// the records one by one, and sort is an insertion sort over one single-port
// record memory that shifts larger records up while it looks for the slot of
// each record. The single memory port serialises every table walk, one access
// at a time.
module session_record_sort_search_table_core #(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [16:0] power_in,
  input  logic [14:0] hours_in,
  input  logic [13:0] tariff_in,
  input  logic [7:0]  search_id,
  input  logic [6:0]  position,
  input  logic [1:0]  sort_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  rec_id,
  output logic [16:0] rec_power,
  output logic [14:0] rec_hours,
  output logic [13:0] rec_tariff,
  output logic [37:0] energy_value,
  output logic [50:0] cost_value,
  output logic [7:0]  entry_total,
  output logic [43:0] avg_cost,
  output logic [30:0] max_energy,
  output logic [30:0] min_energy
);
  import srst_pkg::*;
  `include "session_record_sort_search_table_core_macros.svh"

  localparam int AW = $clog2(CAPACITY);

  rec_t mem [CAPACITY];
  rec_t rd_data;
  logic [AW-1:0] mem_addr;
  logic mem_we;
  rec_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  state_t state, state_next;
  logic [7:0]  count;
  logic [37:0] energy_sum;
  logic [51:0] revenue_sum;
  logic [30:0] energy_max, energy_min;

  // Latched request.
  logic [16:0] p_r;
  logic [14:0] h_r;
  logic [13:0] t_r;
  logic [7:0]  sid_r;
  logic [1:0]  key_r;
  logic [30:0] prod_e;
  logic [44:0] prod_c;
  logic [7:0]  idx_i, idx_j;
  rec_t        cur;
  logic [44:0] cur_key;

  // Result register.
  logic [2:0]  res_status;
  rec_t        res_rec;
  logic        res_rec_en, res_stats;
  logic [51:0] quot;
  logic        div_start, div_done;

  srst_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(revenue_sum),
    .divisor(count), .done(div_done), .quotient(quot)
  );

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  logic add_bad;
  assign add_bad = (power_in == 17'd0) || (power_in > POWER_MAX) ||
                   (hours_in == 15'd0) || (hours_in > HOURS_MAX) ||
                   (tariff_in > TARIFF_MAX);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        state_next = S_OUT;
        case (mode)
          MODE_ADD:
            if (count < 8'(CAPACITY) && !add_bad) state_next = S_ADD_MUL1;
          MODE_READ:
            if (count != 8'd0 && {1'b0, position} < count) state_next = S_READ_WAIT;
          MODE_FIND:
            if (count != 8'd0 && search_id != 8'd0 && search_id <= 8'(CAPACITY))
              state_next = S_FIND_RD;
          MODE_SORT:
            if (count > 8'd1) state_next = S_SORT_RDI;
          MODE_STATS:
            if (count != 8'd0) state_next = S_DIV;
          default: state_next = S_OUT;
        endcase
      end
      S_ADD_MUL1:  state_next = S_ADD_MUL2;
      S_ADD_MUL2:  state_next = S_ADD_CMUL;
      S_ADD_CMUL:  state_next = S_ADD_WR;
      S_ADD_WR:    state_next = S_OUT;
      S_READ_WAIT: state_next = S_OUT;
      S_FIND_RD:   state_next = S_FIND_CHK;
      S_FIND_CHK:
        if (rd_data.id == sid_r || idx_i + 8'd1 >= count) state_next = S_OUT;
        else state_next = S_FIND_RD;
      S_SORT_RDI:  state_next = S_SORT_WI;
      S_SORT_WI:   state_next = S_SORT_RDJ;
      S_SORT_RDJ:  state_next = S_SORT_CMP;
      S_SORT_CMP:
        if (key_of(rd_data, key_r) > cur_key) state_next = (idx_j == 8'd1) ?
          S_SORT_PUT : S_SORT_RDJ;
        else state_next = S_SORT_PUT;
      S_SORT_PUT:
        state_next = (idx_i + 8'd1 >= count) ? S_OUT : S_SORT_RDI;
      S_DIV:       if (div_done) state_next = S_OUT;
      S_OUT:       if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_i[AW-1:0];
    mem_wdata = cur;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        mem_addr  = AW'(position);
        div_start = accept && (mode == MODE_STATS) && (count != 8'd0);
      end
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = count[AW-1:0];
        mem_wdata = '{id: count + 8'd1, power: p_r, hours: h_r, tariff: t_r,
                      energy: prod_e, cost: prod_c};
      end
      S_SORT_RDJ: mem_addr = AW'(idx_j - 8'd1);
      S_SORT_CMP: begin
        // Shift the larger record up one slot.
        mem_addr  = idx_j[AW-1:0];
        mem_wdata = rd_data;
        mem_we    = key_of(rd_data, key_r) > cur_key;
      end
      S_SORT_PUT: begin
        mem_addr  = idx_j[AW-1:0];
        mem_we    = 1'b1;
        mem_wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= 8'd0;
      energy_sum <= 38'd0;
      revenue_sum <= 52'd0;
      energy_max <= 31'd0;
      energy_min <= 31'd0;
    end else begin
      state <= state_next;
      if (state == S_ADD_WR) begin
        count <= count + 8'd1;
        energy_sum <= energy_sum + 38'(prod_e);
        revenue_sum <= revenue_sum + 52'(prod_c);
        if (count == 8'd0 || prod_e > energy_max) energy_max <= prod_e;
        if (count == 8'd0 || prod_e < energy_min) energy_min <= prod_e;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (accept) begin
        p_r <= power_in; h_r <= hours_in; t_r <= tariff_in;
        sid_r <= search_id; key_r <= sort_key;
        idx_i <= (mode == MODE_SORT) ? 8'd1 : 8'd0;
        res_rec_en <= 1'b0;
        res_stats  <= 1'b0;
        res_status <= ST_OK;
        case (mode)
          MODE_ADD:
            if (count >= 8'(CAPACITY)) res_status <= ST_FULL;
            else if (add_bad) res_status <= ST_INVALID;
          MODE_READ:
            if (count == 8'd0) res_status <= ST_EMPTY;
            else if ({1'b0, position} >= count) res_status <= ST_INVALID;
          MODE_FIND:
            if (count == 8'd0) res_status <= ST_EMPTY;
            else if (search_id == 8'd0 || search_id > 8'(CAPACITY))
              res_status <= ST_INVALID;
          MODE_SORT:
            if (count == 8'd0) res_status <= ST_EMPTY;
          MODE_STATS: ;
          default: res_status <= ST_INVALID;
        endcase
      end
      S_ADD_MUL1: prod_e <= 31'(p_r * h_r);
      S_ADD_MUL2: ;
      S_ADD_CMUL: prod_c <= 45'(prod_e * t_r);
      S_ADD_WR: begin
        res_rec <= '{id: count + 8'd1, power: p_r, hours: h_r, tariff: t_r,
                     energy: prod_e, cost: prod_c};
        res_rec_en <= 1'b1;
      end
      S_READ_WAIT: begin
        res_rec <= rd_data;
        res_rec_en <= 1'b1;
      end
      S_FIND_CHK: begin
        if (rd_data.id == sid_r) begin
          res_rec <= rd_data;
          res_rec_en <= 1'b1;
        end else begin
          idx_i <= idx_i + 8'd1;
          if (idx_i + 8'd1 >= count) res_status <= ST_NOTFOUND;
        end
      end
      S_SORT_WI: begin
        cur     <= rd_data;
        cur_key <= key_of(rd_data, key_r);
        idx_j   <= idx_i;
      end
      S_SORT_CMP:
        if (key_of(rd_data, key_r) > cur_key && idx_j != 8'd1) idx_j <= idx_j - 8'd1;
        else if (key_of(rd_data, key_r) > cur_key) idx_j <= 8'd0;
      S_SORT_PUT: idx_i <= idx_i + 8'd1;
      S_DIV: if (div_done) res_stats <= 1'b1;
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    out_valid    = (state == S_OUT);
    status       = res_status;
    entry_total  = count;
    rec_id = 8'd0; rec_power = 17'd0; rec_hours = 15'd0; rec_tariff = 14'd0;
    energy_value = 38'd0; cost_value = 51'd0;
    avg_cost = 44'd0; max_energy = 31'd0; min_energy = 31'd0;
    if (res_rec_en) begin
      rec_id = res_rec.id; rec_power = res_rec.power; rec_hours = res_rec.hours;
      rec_tariff = res_rec.tariff; energy_value = 38'(res_rec.energy);
      cost_value = 51'(res_rec.cost);
    end else if (res_stats) begin
      energy_value = energy_sum; cost_value = revenue_sum[50:0];
      avg_cost = quot[43:0]; max_energy = energy_max; min_energy = energy_min;
    end
  end

  `SRT_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, count <= 8'(CAPACITY), "count above capacity")
  `SRT_ASSERT_IMP(a_stall_busy, clk, rst, state != S_IDLE, in_stall, "busy without stall")
  `SRT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status),
                  "stalled result changed")
  `SRT_ASSERT_IMP(a_rec_excl, clk, rst, out_valid, !(res_rec_en && res_stats),
                  "record and stats both set")
endmodule
